// ===== hdl/rational_arithmetic_reduce_unit_assert.svh =====
// Assertion macros shared by the rational reduce unit.
// No dependencies; included by the top level of the block.
`ifndef RATIONAL_ARITHMETIC_REDUCE_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_REDUCE_UNIT_ASSERT_SVH

// Implication checked in the same cycle.
`define RAR_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rational reduce unit check failed");

// Implication checked in the cycle after the antecedent.
`define RAR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rational reduce unit check failed");

`endif

// ===== hdl/rar_pkg.sv =====
// Package for the rational reduce unit: widths, word types, codes and helpers.
// No dependencies; used by every module of the block.
package rar_pkg;

    // Operand width of each fraction field.
    localparam int RAR_OPD_W  = 16;
    // Width of the intermediate numerator and denominator (capped at 64 bits).
    localparam int RAR_INT_W  = (2 * RAR_OPD_W + 1 > 64) ? 64 : 2 * RAR_OPD_W + 1;
    // Shared adder width: two guard bits over the intermediate width.
    localparam int RAR_ALU_W  = RAR_INT_W + 2;
    // Division step counter and common power-of-two counter.
    localparam int RAR_CNT_W  = $clog2(RAR_INT_W);
    localparam int RAR_K_W    = $clog2(RAR_INT_W);
    // Result field widths and the width they are taken from.
    localparam int RAR_NUM_W  = 33;
    localparam int RAR_DEN_W  = 32;
    localparam int RAR_WIDE_W = 64;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } rar_op_t;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } rar_alu_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_COMB,
        ST_MAGN,
        ST_MAGD,
        ST_GCD,
        ST_GSHIFT,
        ST_DIVN,
        ST_DIVD,
        ST_SIGNN,
        ST_SIGND,
        ST_OUT
    } rar_state_t;

    typedef struct packed {
        rar_op_t                       op;
        logic signed [RAR_OPD_W-1:0]   num_a;
        logic signed [RAR_OPD_W-1:0]   den_a;
        logic signed [RAR_OPD_W-1:0]   num_b;
        logic signed [RAR_OPD_W-1:0]   den_b;
    } rar_in_t;

    typedef struct packed {
        logic signed [RAR_NUM_W-1:0]   res_num;
        logic signed [RAR_DEN_W-1:0]   res_den;
        logic                          zero_den;
    } rar_out_t;

    // Zero-extend an intermediate word to the shared adder width.
    function automatic logic [RAR_ALU_W-1:0] rar_zext(input logic [RAR_INT_W-1:0] v);
        return RAR_ALU_W'(v);
    endfunction

endpackage

// ===== hdl/rar_mul.sv =====
// Signed operand multiplier of the rational reduce unit.
// Depends on rar_pkg for the operand width.
module rar_mul (
    input  logic signed [rar_pkg::RAR_OPD_W-1:0]   mul_a,
    input  logic signed [rar_pkg::RAR_OPD_W-1:0]   mul_b,
    output logic signed [2*rar_pkg::RAR_OPD_W-1:0] mul_p
);
    import rar_pkg::*;

    // Full-width signed product; the result is registered by the caller.
    assign mul_p = mul_a * mul_b;

endmodule

// ===== hdl/rar_alu.sv =====
// Shared add/subtract unit of the rational reduce unit.
// Depends on rar_pkg for the adder width and the operation codes.
module rar_alu (
    input  rar_pkg::rar_alu_op_t         alu_op,
    input  logic [rar_pkg::RAR_ALU_W-1:0] alu_x,
    input  logic [rar_pkg::RAR_ALU_W-1:0] alu_y,
    output logic [rar_pkg::RAR_ALU_W-1:0] alu_r
);
    import rar_pkg::*;

    // One adder serves sums, differences, negations, compares and division steps.
    always_comb begin
        case (alu_op)
            ALU_ADD: alu_r = alu_x + alu_y;
            ALU_SUB: alu_r = alu_x - alu_y;
            default: alu_r = alu_x;
        endcase
    end

endmodule

// ===== hdl/rational_arithmetic_reduce_unit.sv =====
// Rational reduce unit: fraction add, subtract, multiply or divide, then GCD reduction.
// Depends on rar_pkg, rar_mul, rar_alu and rational_arithmetic_reduce_unit_assert.svh.
//
// Usage: the input channel (s_valid, s_ready, s_data) carries one word with the
// operation and two fractions. The result channel (m_valid, m_ready, m_data) returns
// one word per input: the reduced numerator and denominator with their signs as
// computed, and zero_den when the denominator came out zero (numerator unreduced).
// One word is in work at a time; s_ready is high only while the unit waits for input.
// The work per word grows with W, the intermediate width (33 bits for 16-bit operands),
// with G, the binary GCD steps (each a shift, a swap or one subtract; a swap can
// precede every subtract), and with K, the common factors of two, restored one shift
// a cycle. A zero denominator skips the magnitude, GCD, division and sign steps.
// The shared multiplier forms the three cross products one after another, and the
// shared adder carries the combine, magnitudes, GCD, both restoring divisions and
// the sign restore. A finished word sits in the output register, and the next input
// word is accepted and worked on while it waits; if the receiver still stalls when
// the next result is ready, the sequencer holds it until the register frees.
// Reset (aresetn low, synchronous) returns the sequencer to idle and drops m_valid.
`include "rational_arithmetic_reduce_unit_assert.svh"
module rational_arithmetic_reduce_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  rar_pkg::rar_in_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output rar_pkg::rar_out_t  m_data
);
    import rar_pkg::*;

    // Control registers.
    rar_state_t state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    // Payload registers.
    rar_op_t                     op_reg, op_next;
    logic signed [RAR_OPD_W-1:0] na_reg, na_next;
    logic signed [RAR_OPD_W-1:0] da_reg, da_next;
    logic signed [RAR_OPD_W-1:0] nb_reg, nb_next;
    logic signed [RAR_OPD_W-1:0] db_reg, db_next;
    logic signed [RAR_INT_W-1:0] m0_reg, m0_next;
    logic signed [RAR_INT_W-1:0] m1_reg, m1_next;
    logic signed [RAR_INT_W-1:0] num_reg, num_next;
    logic signed [RAR_INT_W-1:0] den_reg, den_next;
    logic [RAR_INT_W-1:0]        mn_reg, mn_next;
    logic [RAR_INT_W-1:0]        md_reg, md_next;
    logic [RAR_INT_W-1:0]        a_reg, a_next;
    logic [RAR_INT_W-1:0]        b_reg, b_next;
    logic [RAR_INT_W-1:0]        q_reg, q_next;
    logic [RAR_INT_W-1:0]        rem_reg, rem_next;
    logic [RAR_CNT_W-1:0]        cnt_reg, cnt_next;
    logic [RAR_K_W-1:0]          k_reg, k_next;
    logic                        zero_reg, zero_next;
    rar_out_t                    m_data_reg, m_data_next;

    // Shared unit connections.
    logic signed [RAR_OPD_W-1:0]   mul_a, mul_b;
    logic signed [2*RAR_OPD_W-1:0] mul_p;
    logic signed [RAR_INT_W-1:0]   mul_ext;
    rar_alu_op_t                   alu_op;
    logic [RAR_ALU_W-1:0]          alu_x, alu_y, alu_r;
    logic                          div_ge;
    logic [RAR_INT_W-1:0]          div_shift;
    logic signed [RAR_WIDE_W-1:0]  num_wide, den_wide;

    rar_mul u_mul (
        .mul_a (mul_a),
        .mul_b (mul_b),
        .mul_p (mul_p)
    );

    rar_alu u_alu (
        .alu_op (alu_op),
        .alu_x  (alu_x),
        .alu_y  (alu_y),
        .alu_r  (alu_r)
    );

    // Signed products extend to the intermediate width.
    assign mul_ext = RAR_INT_W'(mul_p);

    // A division step succeeds when the trial subtraction does not borrow.
    assign div_ge    = ~alu_r[RAR_ALU_W-1];
    assign div_shift = {rem_reg[RAR_INT_W-2:0], q_reg[RAR_INT_W-1]};

    // Results are read from the intermediate words sign-extended to 64 bits.
    assign num_wide = RAR_WIDE_W'(num_reg);
    assign den_wide = RAR_WIDE_W'(den_reg);

    // Sequencer: next state, operand selection and register updates.
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        op_next      = op_reg;
        na_next      = na_reg;
        da_next      = da_reg;
        nb_next      = nb_reg;
        db_next      = db_reg;
        m0_next      = m0_reg;
        m1_next      = m1_reg;
        num_next     = num_reg;
        den_next     = den_reg;
        mn_next      = mn_reg;
        md_next      = md_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        q_next       = q_reg;
        rem_next     = rem_reg;
        cnt_next     = cnt_reg;
        k_next       = k_reg;
        zero_next    = zero_reg;
        m_data_next  = m_data_reg;
        s_ready      = 1'b0;
        mul_a        = da_reg;
        mul_b        = db_reg;
        alu_op       = ALU_SUB;
        alu_x        = '0;
        alu_y        = '0;

        // The output register frees once its word is taken.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                s_ready = aresetn;
                if (s_valid && s_ready) begin
                    op_next    = s_data.op;
                    na_next    = s_data.num_a;
                    da_next    = s_data.den_a;
                    nb_next    = s_data.num_b;
                    db_next    = s_data.den_b;
                    zero_next  = 1'b0;
                    k_next     = '0;
                    state_next = ST_MUL0;
                end
            end

            // First product: the numerator term that carries num_a.
            ST_MUL0: begin
                mul_a      = na_reg;
                mul_b      = (op_reg == OP_MUL) ? nb_reg : db_reg;
                m0_next    = mul_ext;
                state_next = ST_MUL1;
            end

            // Second product: den_a times num_b.
            ST_MUL1: begin
                mul_a      = da_reg;
                mul_b      = nb_reg;
                m1_next    = mul_ext;
                state_next = ST_MUL2;
            end

            // Denominator: den_a times den_b, or the second product for divide.
            ST_MUL2: begin
                mul_a      = da_reg;
                mul_b      = db_reg;
                den_next   = (op_reg == OP_DIV) ? m1_reg : mul_ext;
                state_next = ST_COMB;
            end

            // Combine the numerator terms and catch a zero denominator.
            ST_COMB: begin
                alu_op = (op_reg == OP_SUB) ? ALU_SUB : ALU_ADD;
                alu_x  = rar_zext(m0_reg);
                alu_y  = rar_zext(m1_reg);
                if (op_reg == OP_ADD || op_reg == OP_SUB) begin
                    num_next = alu_r[RAR_INT_W-1:0];
                end else begin
                    num_next = m0_reg;
                end
                if (den_reg == '0) begin
                    zero_next  = 1'b1;
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_MAGN;
                end
            end

            // Magnitude of the numerator.
            ST_MAGN: begin
                alu_y = rar_zext(num_reg);
                if (num_reg[RAR_INT_W-1]) begin
                    mn_next = alu_r[RAR_INT_W-1:0];
                end else begin
                    mn_next = num_reg;
                end
                a_next     = mn_next;
                state_next = ST_MAGD;
            end

            // Magnitude of the denominator.
            ST_MAGD: begin
                alu_y = rar_zext(den_reg);
                if (den_reg[RAR_INT_W-1]) begin
                    md_next = alu_r[RAR_INT_W-1:0];
                end else begin
                    md_next = den_reg;
                end
                b_next     = md_next;
                state_next = ST_GCD;
            end

            // Binary GCD: one halving, swap or subtract per cycle.
            ST_GCD: begin
                alu_x = rar_zext(a_reg);
                alu_y = rar_zext(b_reg);
                if (a_reg == '0) begin
                    state_next = ST_GSHIFT;
                end else if (b_reg == '0) begin
                    b_next     = a_reg;
                    state_next = ST_GSHIFT;
                end else if (!a_reg[0] && !b_reg[0]) begin
                    a_next = a_reg >> 1;
                    b_next = b_reg >> 1;
                    k_next = k_reg + 1'b1;
                end else if (!a_reg[0]) begin
                    a_next = a_reg >> 1;
                end else if (!b_reg[0]) begin
                    b_next = b_reg >> 1;
                end else if (alu_r[RAR_ALU_W-1]) begin
                    a_next = b_reg;
                    b_next = a_reg;
                end else begin
                    a_next = {1'b0, alu_r[RAR_INT_W-1:1]};
                end
            end

            // Restore the common factors of two, then set up the numerator division.
            ST_GSHIFT: begin
                if (k_reg == '0) begin
                    q_next     = mn_reg;
                    rem_next   = '0;
                    cnt_next   = RAR_CNT_W'(RAR_INT_W - 1);
                    state_next = ST_DIVN;
                end else begin
                    b_next = b_reg << 1;
                    k_next = k_reg - 1'b1;
                end
            end

            // Restoring division of the numerator magnitude by the GCD.
            ST_DIVN: begin
                alu_x    = {1'b0, rem_reg, q_reg[RAR_INT_W-1]};
                alu_y    = rar_zext(b_reg);
                rem_next = div_ge ? alu_r[RAR_INT_W-1:0] : div_shift;
                q_next   = {q_reg[RAR_INT_W-2:0], div_ge};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    mn_next    = {q_reg[RAR_INT_W-2:0], div_ge};
                    q_next     = md_reg;
                    rem_next   = '0;
                    cnt_next   = RAR_CNT_W'(RAR_INT_W - 1);
                    state_next = ST_DIVD;
                end
            end

            // Restoring division of the denominator magnitude by the GCD.
            ST_DIVD: begin
                alu_x    = {1'b0, rem_reg, q_reg[RAR_INT_W-1]};
                alu_y    = rar_zext(b_reg);
                rem_next = div_ge ? alu_r[RAR_INT_W-1:0] : div_shift;
                q_next   = {q_reg[RAR_INT_W-2:0], div_ge};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_SIGNN;
                end
            end

            // Give the reduced numerator back its computed sign.
            ST_SIGNN: begin
                alu_y = rar_zext(mn_reg);
                if (num_reg[RAR_INT_W-1]) begin
                    num_next = alu_r[RAR_INT_W-1:0];
                end else begin
                    num_next = mn_reg;
                end
                state_next = ST_SIGND;
            end

            // Give the reduced denominator back its computed sign.
            ST_SIGND: begin
                alu_y = rar_zext(q_reg);
                if (den_reg[RAR_INT_W-1]) begin
                    den_next = alu_r[RAR_INT_W-1:0];
                end else begin
                    den_next = q_reg;
                end
                state_next = ST_OUT;
            end

            // Load the output register as soon as it is free.
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next.res_num  = num_wide[RAR_NUM_W-1:0];
                    m_data_next.res_den  = den_wide[RAR_DEN_W-1:0];
                    m_data_next.zero_den = zero_reg;
                    m_valid_next         = 1'b1;
                    state_next           = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state with synchronous reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        na_reg     <= na_next;
        da_reg     <= da_next;
        nb_reg     <= nb_next;
        db_reg     <= db_next;
        m0_reg     <= m0_next;
        m1_reg     <= m1_next;
        num_reg    <= num_next;
        den_reg    <= den_next;
        mn_reg     <= mn_next;
        md_reg     <= md_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        q_reg      <= q_next;
        rem_reg    <= rem_next;
        cnt_reg    <= cnt_next;
        k_reg      <= k_next;
        zero_reg   <= zero_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // A zero denominator is reported with a zero result denominator and only then.
    `RAR_ASSERT_IMPL(a_zero_den_flag, aclk, aresetn, m_valid && m_data.zero_den, m_data.res_den == '0)
    `RAR_ASSERT_IMPL(a_reduced_den_nonzero, aclk, aresetn, m_valid && !m_data.zero_den, m_data.res_den != '0)
    // An accepted word keeps the unit busy for the next cycle.
    `RAR_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    // The GCD loop never runs with both operands zero.
    `RAR_ASSERT_IMPL(a_gcd_operands, aclk, aresetn, state_reg == ST_GCD, a_reg != '0 || b_reg != '0)

endmodule

// ===== sim/tb_top.sv =====
// Testbench for the rational reduce unit: a scoreboard class predicts every reduced fraction.
// Depends on rar_pkg and rational_arithmetic_reduce_unit; it needs nothing else.
// Directed corner words come first, then random words with random idling on both channels, save one stretch with none.

// Predicts and checks the result words in order of arrival.
class fraction_scoreboard;
    rar_pkg::rar_out_t pending_results[$];
    int unsigned       mismatches;

    function new();
        mismatches = 0;
    endfunction

    // Sign-extend one operand to the 64-bit working width.
    static function logic [63:0] widen(logic [rar_pkg::RAR_OPD_W-1:0] v);
        return {{(64 - rar_pkg::RAR_OPD_W){v[rar_pkg::RAR_OPD_W-1]}}, v};
    endfunction

    static function logic [63:0] abs64(logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    // Cross-multiplied fraction, reduced by the GCD of the magnitudes; signs kept as formed.
    static function rar_pkg::rar_out_t reduced_fraction(rar_pkg::rar_in_t w);
        logic [63:0]       na, da, nb, db;
        logic [63:0]       top, bottom, a, b, t, qn, qd;
        rar_pkg::rar_out_t r;
        na = widen(w.num_a);
        da = widen(w.den_a);
        nb = widen(w.num_b);
        db = widen(w.den_b);
        case (w.op)
            rar_pkg::OP_ADD: begin
                top    = na * db + da * nb;
                bottom = da * db;
            end
            rar_pkg::OP_SUB: begin
                top    = na * db - da * nb;
                bottom = da * db;
            end
            rar_pkg::OP_MUL: begin
                top    = na * nb;
                bottom = da * db;
            end
            default: begin
                top    = na * db;
                bottom = da * nb;
            end
        endcase
        // A zero denominator passes the numerator through unreduced.
        if (bottom == 64'd0) begin
            r.res_num  = top[rar_pkg::RAR_NUM_W-1:0];
            r.res_den  = '0;
            r.zero_den = 1'b1;
            return r;
        end
        a = abs64(top);
        b = abs64(bottom);
        while (b != 64'd0) begin
            t = a % b;
            a = b;
            b = t;
        end
        qn = abs64(top) / a;
        qd = abs64(bottom) / a;
        if (top[63]) begin
            qn = 64'd0 - qn;
        end
        if (bottom[63]) begin
            qd = 64'd0 - qd;
        end
        r.res_num  = qn[rar_pkg::RAR_NUM_W-1:0];
        r.res_den  = qd[rar_pkg::RAR_DEN_W-1:0];
        r.zero_den = 1'b0;
        return r;
    endfunction

    // Record an accepted input word.
    function void note_word(rar_pkg::rar_in_t w);
        pending_results.push_back(reduced_fraction(w));
    endfunction

    // Compare an accepted result word with the oldest prediction.
    function void check_word(rar_pkg::rar_out_t got);
        rar_pkg::rar_out_t want;
        if (pending_results.size() == 0) begin
            $display("%0t: unexpected result word num=%0d den=%0d zero_den=%0b",
                     $time, got.res_num, got.res_den, got.zero_den);
            mismatches++;
            return;
        end
        want = pending_results.pop_front();
        if (got.res_num !== want.res_num) begin
            $display("%0t: res_num expected %0d actual %0d", $time, want.res_num, got.res_num);
            mismatches++;
        end
        if (got.res_den !== want.res_den) begin
            $display("%0t: res_den expected %0d actual %0d", $time, want.res_den, got.res_den);
            mismatches++;
        end
        if (got.zero_den !== want.zero_den) begin
            $display("%0t: zero_den expected %0b actual %0b",
                     $time, want.zero_den, got.zero_den);
            mismatches++;
        end
    endfunction
endclass

module tb_top;
    import rar_pkg::*;

    typedef logic signed [RAR_OPD_W-1:0] operand_t;

    localparam int IDLE_PCT     = 36;
    localparam int RANDOM_WORDS = 1630;
    localparam int QUIET_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 300;
    localparam int OPD_MAX      = (1 << (RAR_OPD_W - 1)) - 1;
    localparam int OPD_MIN      = -(1 << (RAR_OPD_W - 1));

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    rar_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    rar_out_t m_data;

    int src_idle_pct  = IDLE_PCT;
    int sink_idle_pct = IDLE_PCT;

    fraction_scoreboard book = new();

    rational_arithmetic_reduce_unit DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #4 aclk = ~aclk;

    // Result side: check each accepted word, then pick the next ready level.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            book.check_word(m_data);
        end
        m_ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Watchdog on cycles without any accepted word.
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("%0t: no word accepted for %0d cycles", $time, QUIET_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    // Offer one input word, after a random number of idle cycles, and wait for it to go in.
    task automatic send_fraction(input rar_op_t op, input int na, input int da,
                                 input int nb, input int db);
        rar_in_t w;
        w.op    = op;
        w.num_a = operand_t'(na);
        w.den_a = operand_t'(da);
        w.num_b = operand_t'(nb);
        w.den_b = operand_t'(db);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        book.note_word(w);
    endtask

    // Operand mix: zeros, extremes, small values with shared factors, powers of two, full range.
    function automatic int pick_operand();
        operand_t v;
        case ($urandom_range(9))
            0: v = '0;
            1: begin
                case ($urandom_range(3))
                    0: v = operand_t'(OPD_MIN);
                    1: v = operand_t'(OPD_MAX);
                    2: v = operand_t'(-1);
                    default: v = operand_t'(1);
                endcase
            end
            2, 3, 4: v = operand_t'($urandom_range(40)) - operand_t'(20);
            5: begin
                v = operand_t'(1) << $urandom_range(RAR_OPD_W - 2);
                if ($urandom_range(1) == 1) begin
                    v = -v;
                end
            end
            default: v = operand_t'($urandom());
        endcase
        return int'(v);
    endfunction

    // Stimulus: directed corners, then random words with a long stretch of no idling.
    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_fraction(OP_ADD, 1, 2, 1, 3);
        send_fraction(OP_SUB, 1, 2, 1, 2);
        send_fraction(OP_MUL, 2, 3, 3, 4);
        send_fraction(OP_DIV, 1, 2, 3, 4);
        send_fraction(OP_ADD, OPD_MIN, OPD_MIN, OPD_MIN, OPD_MIN);
        send_fraction(OP_MUL, OPD_MIN, 1, OPD_MIN, 1);
        send_fraction(OP_MUL, OPD_MAX, OPD_MIN, OPD_MAX, OPD_MAX);
        // Zero denominator, from a zero divisor numerator and from a zero operand denominator.
        send_fraction(OP_DIV, 5, 7, 0, 3);
        send_fraction(OP_ADD, 3, 0, 4, 5);
        // Zero numerator over a negative denominator gives 0 over -1.
        send_fraction(OP_SUB, 0, 5, 0, -7);
        send_fraction(OP_DIV, 0, 1, 0, 1);
        send_fraction(OP_ADD, 0, 0, 0, 0);
        send_fraction(OP_SUB, OPD_MIN, OPD_MAX, OPD_MAX, OPD_MIN);
        send_fraction(OP_MUL, -1, -1, -1, -1);
        send_fraction(OP_DIV, OPD_MAX, OPD_MAX, OPD_MAX, OPD_MAX);
        send_fraction(OP_ADD, OPD_MAX, OPD_MAX, OPD_MAX, OPD_MAX);
        send_fraction(OP_MUL, 0, 0, 5, 3);
        send_fraction(OP_DIV, OPD_MIN, -1, OPD_MIN, -1);
        send_fraction(OP_SUB, OPD_MAX, 1, OPD_MIN, 1);
        send_fraction(OP_ADD, 1, OPD_MIN, 1, OPD_MAX);
        send_fraction(OP_MUL, 12, -18, -30, 45);
        send_fraction(OP_DIV, 4096, 2048, 64, 512);

        for (int i = 0; i < RANDOM_WORDS; i++) begin
            if (i >= 500 && i < 850) begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end else begin
                src_idle_pct  = IDLE_PCT;
                sink_idle_pct = IDLE_PCT;
            end
            send_fraction(rar_op_t'($urandom_range(3)), pick_operand(), pick_operand(),
                          pick_operand(), pick_operand());
        end
        s_valid <= 1'b0;

        while (book.pending_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (book.mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
